// ----- src/chm_pkg.sv -----
`default_nettype none
package chm_pkg;
   localparam int MaxBuckets  = 1024;
   localparam int PoolEntries = 1024;
   localparam int BktW  = $clog2(MaxBuckets);
   localparam int PoolW = $clog2(PoolEntries);
   localparam int LinkW = PoolW + 1;
   localparam int CntW  = 11;
   localparam logic [63:0] HashSeed = 64'd5381;
   localparam logic [7:0]  CharZero = 8'd48;

   localparam logic CMD_SET = 1'b0;
   localparam logic CMD_GET = 1'b1;
   localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;

   typedef struct packed {
      logic       cmd;
      logic [31:0] key;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [63:0] value_out;
      logic [9:0]  bucket;
      logic        status;
   } rsp_type;

   // hash unit handshake
   typedef struct packed {
      logic        start;
      logic [31:0] key;
      logic [CntW-1:0] divisor;
   } hash_ctl_type;

   typedef struct packed {
      logic             done;
      logic [BktW-1:0]  bucket;
   } hash_sts_type;
endpackage
`default_nettype wire

// ----- src/chm_stream_if.sv -----
`default_nettype none
interface chm_stream_if #(parameter int W = 1) (input wire logic clock);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/chm_hash.sv -----
`default_nettype none
// Decimal digits by repeated divide by ten, then djb2 over the digits
// (most significant first), then restoring remainder by the bucket count.
module chm_hash import chm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire hash_ctl_type ctl,
   output hash_sts_type      sts
);
   typedef enum logic [1:0] {S_IDLE, S_DIG, S_HASH, S_MOD} state_type;
   state_type   state_ff, state_in;
   logic [31:0] k_ff, k_in;
   logic [3:0]  dig_ff [10];
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] h_ff, h_in;
   logic [CntW-1:0] div_ff, div_in;
   logic [CntW-1:0] rem_ff, rem_in;
   logic [5:0]  bit_ff, bit_in;
   logic [BktW-1:0] bkt_ff, bkt_in;
   logic        done_ff, done_in;
   logic [31:0] q10;
   logic [3:0]  r10;
   logic [35:0] q_mul;
   logic [CntW:0] trial;

   // k/10 via reciprocal multiply, valid for all 32-bit k
   always_comb begin
      q_mul = 36'((64'(k_ff) * 64'hCCCCCCCD) >> 35);
      q10   = q_mul[31:0];
      r10   = 4'(k_ff - q10 * 32'd10);
      trial = {rem_ff, h_ff[63]} - {1'b0, div_ff};
   end

   always_comb begin
      state_in = state_ff; k_in = k_ff; cnt_in = cnt_ff; h_in = h_ff;
      div_in = div_ff; rem_in = rem_ff; bit_in = bit_ff; bkt_in = bkt_ff;
      done_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (ctl.start) begin
            k_in = ctl.key; cnt_in = '0; h_in = HashSeed;
            div_in = (ctl.divisor == '0) ? CntW'(1) :
                     (ctl.divisor > CntW'(MaxBuckets)) ? CntW'(MaxBuckets) : ctl.divisor;
            state_in = S_DIG;
         end
         S_DIG: begin
            k_in = q10; cnt_in = cnt_ff + 4'd1;
            if (q10 == '0 || cnt_ff == 4'd9) state_in = S_HASH;
         end
         S_HASH: begin
            cnt_in = cnt_ff - 4'd1;
            h_in = (h_ff << 5) + h_ff + 64'({CharZero[7:4], dig_ff[cnt_in]});
            if (cnt_in == '0) begin
               state_in = S_MOD; rem_in = '0; bit_in = '0;
            end
         end
         S_MOD: begin
            h_in = h_ff << 1;
            rem_in = trial[CntW] ? {rem_ff[CntW-2:0], h_ff[63]} : trial[CntW-1:0];
            bit_in = bit_ff + 6'd1;
            if (bit_ff == 6'd63) begin
               bkt_in = BktW'(rem_in); done_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; done_ff <= 1'b0;
      end else begin
         state_ff <= state_in; done_ff <= done_in;
      end
      k_ff <= k_in; cnt_ff <= cnt_in; h_ff <= h_in; div_ff <= div_in;
      rem_ff <= rem_in; bit_ff <= bit_in; bkt_ff <= bkt_in;
      if (state_ff == S_DIG) dig_ff[cnt_ff] <= r10;
   end

   assign sts.done   = done_ff;
   assign sts.bucket = bkt_ff;

   a_mod_below_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MOD |-> rem_ff < div_ff) else $error("remainder out of range");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held");
   a_dig_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIG |-> cnt_ff <= 4'd9) else $error("digit overflow");
endmodule
`default_nettype wire

// ----- src/chained_hash_map_unit.sv -----
`default_nettype none
// Chained hash map. One request item (set or get) at a time; req_ready is low
// while an item is at work. Each item passes these steps in order: the hash
// unit takes one digit step per decimal digit (1..10), one djb2 step per
// digit and restoring remainder steps over all 64 hash bits, then raises its
// registered done flag. The head read then runs through S_HEAD and S_HEADW,
// and the chain walk runs S_ENT and S_ENTW for each entry visited, plus one
// more S_ENT check when the walk ends without a match. S_UPD follows, and
// then the result is offered in S_OUT until it is taken. The unit then
// returns to S_IDLE, and only there is the next item accepted. After reset a
// clearing pass writes all 1024 bucket heads as empty; no item is taken
// until it ends.
// Register 0 (bucket_count) sits at address 0.
module chained_hash_map_unit import chm_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   chm_stream_if.sink   req,
   chm_stream_if.source rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [0:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   typedef enum logic [3:0] {S_CLR, S_IDLE, S_HASH, S_HEAD, S_HEADW, S_ENT,
                             S_ENTW, S_UPD, S_OUT} state_type;
   state_type state_ff, state_in;

   logic [CntW-1:0] bcnt_ff;
   logic [CntW-1:0] used_ff, used_in;
   logic [BktW-1:0] clr_ff, clr_in;
   req_type  req_ff, req_in;
   rsp_type  rsp_ff, rsp_in;
   logic     rsp_vld_ff, rsp_vld_in;
   logic [LinkW-1:0] cur_ff, cur_in;
   logic [CntW-1:0]  steps_ff, steps_in;
   logic [BktW-1:0]  bkt_ff, bkt_in;
   hash_ctl_type hctl;
   hash_sts_type hsts;

   // memories
   logic [LinkW-1:0] heads_mem [MaxBuckets];
   logic [31:0]      keys_mem  [PoolEntries];
   logic [63:0]      vals_mem  [PoolEntries];
   logic [LinkW-1:0] links_mem [PoolEntries];
   logic [LinkW-1:0] head_rd_ff, link_rd_ff;
   logic [31:0]      key_rd_ff;
   logic [63:0]      val_rd_ff;
   logic             head_we, ent_we, val_we;
   logic [BktW-1:0]  head_addr;
   logic [LinkW-1:0] head_wd;
   logic [PoolW-1:0] ent_addr;

   assign csr_pready = 1'b1;
   assign csr_prdata = 32'(bcnt_ff);
   always_ff @(posedge clock) begin
      if (reset) bcnt_ff <= CntW'(1024);
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_BUCKET_COUNT)
         bcnt_ff <= csr_pwdata[CntW-1:0];
   end

   assign hctl.start   = (state_ff == S_IDLE) && req.valid;
   assign hctl.key     = req.data[95:64];
   assign hctl.divisor = bcnt_ff;
   chm_hash u_hash (.clock, .reset, .ctl(hctl), .sts(hsts));

   logic chain_ok;
   assign chain_ok = (cur_ff < LinkW'(used_ff)) && (steps_ff <= used_ff);

   always_comb begin
      state_in = state_ff; used_in = used_ff; clr_in = clr_ff; req_in = req_ff;
      rsp_in = rsp_ff; rsp_vld_in = rsp_vld_ff; cur_in = cur_ff; steps_in = steps_ff;
      bkt_in = bkt_ff;
      head_we = 1'b0; ent_we = 1'b0; val_we = 1'b0;
      head_addr = bkt_ff; head_wd = LinkW'(PoolEntries);
      ent_addr = cur_ff[PoolW-1:0];
      unique case (state_ff)
         S_CLR: begin
            head_we = 1'b1; head_addr = clr_ff; clr_in = clr_ff + 1'b1;
            if (clr_ff == BktW'(MaxBuckets - 1)) state_in = S_IDLE;
         end
         S_IDLE: if (req.valid) begin
            req_in = req.data; state_in = S_HASH;
         end
         S_HASH: if (hsts.done) begin
            bkt_in = hsts.bucket; head_addr = hsts.bucket; state_in = S_HEAD;
         end
         S_HEAD: state_in = S_HEADW;
         S_HEADW: begin
            cur_in = head_rd_ff; steps_in = '0; state_in = S_ENT;
         end
         S_ENT: begin
            if (chain_ok) state_in = S_ENTW;
            else state_in = S_UPD;
         end
         S_ENTW: begin
            if (key_rd_ff == req_ff.key) state_in = S_UPD;
            else begin
               cur_in = link_rd_ff; steps_in = steps_ff + 1'b1; state_in = S_ENT;
            end
         end
         S_UPD: begin
            rsp_in.hit = chain_ok; rsp_in.bucket = 10'(bkt_ff);
            rsp_in.value_out = '0; rsp_in.status = 1'b0;
            if (req_ff.cmd == CMD_GET) begin
               if (chain_ok) rsp_in.value_out = val_rd_ff;
            end else if (chain_ok) begin
               val_we = 1'b1;
            end else if (used_ff >= CntW'(PoolEntries)) begin
               rsp_in.status = 1'b1;
            end else begin
               ent_we = 1'b1; val_we = 1'b1; ent_addr = used_ff[PoolW-1:0];
               head_we = 1'b1; head_wd = LinkW'(used_ff);
               used_in = used_ff + 1'b1;
            end
            rsp_vld_in = 1'b1; state_in = S_OUT;
         end
         S_OUT: if (rsp.ready) begin
            rsp_vld_in = 1'b0; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold cur_ff at the hit entry so its value is read next to the key
   always_ff @(posedge clock) begin
      if (head_we) heads_mem[head_addr] <= head_we ? head_wd : head_wd;
      head_rd_ff <= heads_mem[head_addr];
      if (ent_we) begin
         keys_mem[ent_addr]  <= req_ff.key;
         links_mem[ent_addr] <= head_rd_ff;
      end
      if (val_we) vals_mem[ent_addr] <= req_ff.value;
      key_rd_ff  <= keys_mem[ent_addr];
      link_rd_ff <= links_mem[ent_addr];
      val_rd_ff  <= vals_mem[ent_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; used_ff <= '0; clr_ff <= '0; rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; used_ff <= used_in; clr_ff <= clr_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      req_ff <= req_in; rsp_ff <= rsp_in; cur_ff <= cur_in; steps_ff <= steps_in;
      bkt_ff <= bkt_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_vld_ff;
   assign rsp.data  = rsp_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !req.ready) else $error("accepting while result pending");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CntW'(PoolEntries)) else $error("pool count overflow");
   a_status_set: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.status |-> !rsp_ff.hit && req_ff.cmd == CMD_SET)
      else $error("bad full status");
endmodule
`default_nettype wire
